// ----- sv/tmw_pkg.sv -----
// Shared definitions for the text mode terminal writer.
// Holds screen geometry, field widths, character and command codes and the
// command record passed from the front end to the engine. No dependencies.
package tmw_pkg;

  // Screen geometry.
  localparam int unsigned COLUMNS     = 80;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned SCREEN_SIZE = ROWS * COLUMNS;
  localparam int unsigned COPY_CELLS  = SCREEN_SIZE - COLUMNS;
  localparam int unsigned LAST_ROW_START = (ROWS - 1) * COLUMNS;

  // Internal widths that follow from the geometry.
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam int unsigned COL_W = $clog2(COLUMNS);
  localparam int unsigned POS_W = $clog2(SCREEN_SIZE);

  // Port field widths.
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned IDX_W     = 11;
  localparam int unsigned OUT_ROW_W = 5;
  localparam int unsigned OUT_COL_W = 7;
  localparam int unsigned OUT_POS_W = 11;
  localparam int unsigned CELL_W    = 16;
  localparam int unsigned COLOR_W   = 4;
  localparam int unsigned ATTR_W    = 2 * COLOR_W;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'd1;
  localparam logic [COLOR_W-1:0]   FG_RESET       = 4'd7;
  localparam logic [COLOR_W-1:0]   BG_RESET       = 4'd0;
  localparam logic [ATTR_W-1:0]    RESET_ATTR     = 8'h07;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam int unsigned       TAB_STOP   = 4;

  // Command codes produced by the front end.
  localparam int unsigned OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP     = 3'd0;
  localparam logic [OP_W-1:0] OP_PUT     = 3'd1;
  localparam logic [OP_W-1:0] OP_NEWLINE = 3'd2;
  localparam logic [OP_W-1:0] OP_RETURN  = 3'd3;
  localparam logic [OP_W-1:0] OP_TAB     = 3'd4;
  localparam logic [OP_W-1:0] OP_READ    = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd6;

  // Command queue depth.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // One classified command.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  idx;
  } cmd_t;

endpackage

// ----- sv/tmw_front.sv -----
// Front end of the text mode terminal writer: accepts input transactions,
// decodes them into commands and hands them to the command queue.
// Depends on tmw_pkg.
module tmw_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tmw_pkg::KIND_W-1:0] in_kind,
  input  logic [tmw_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tmw_pkg::IDX_W-1:0]  in_cell_index,
  input  logic                       engine_ready,
  input  logic                       q_full,
  output logic                       q_push,
  output tmw_pkg::cmd_t              q_push_data
);

  localparam int unsigned POS_W = tmw_pkg::POS_W;

  tmw_pkg::cmd_t cmd_in;
  tmw_pkg::cmd_t hold_cmd_r;
  tmw_pkg::cmd_t hold_cmd_nxt;
  logic          hold_valid_r;
  logic          hold_valid_nxt;
  logic          in_accept;
  logic [31:0]   idx_ext;

  // Decode the incoming item into a command.
  always_comb begin
    idx_ext    = 32'(in_cell_index);
    cmd_in.ch  = in_char_code;
    cmd_in.idx = idx_ext[POS_W-1:0];
    case (in_kind)
      tmw_pkg::KIND_WRITE: begin
        if (in_char_code == tmw_pkg::CH_NEWLINE) begin
          cmd_in.op = tmw_pkg::OP_NEWLINE;
        end else if (in_char_code == tmw_pkg::CH_RETURN) begin
          cmd_in.op = tmw_pkg::OP_RETURN;
        end else if (in_char_code == tmw_pkg::CH_TAB) begin
          cmd_in.op = tmw_pkg::OP_TAB;
        end else if (in_char_code < tmw_pkg::CH_SPACE) begin
          cmd_in.op = tmw_pkg::OP_NOP;
        end else begin
          cmd_in.op = tmw_pkg::OP_PUT;
        end
      end
      tmw_pkg::KIND_READ: begin
        // A read outside the screen reports zero data, like a no-op.
        if (idx_ext < tmw_pkg::SCREEN_SIZE) begin
          cmd_in.op = tmw_pkg::OP_READ;
        end else begin
          cmd_in.op = tmw_pkg::OP_NOP;
        end
      end
      tmw_pkg::KIND_CLEAR: begin
        cmd_in.op = tmw_pkg::OP_CLEAR;
      end
      default: begin
        cmd_in.op = tmw_pkg::OP_NOP;
      end
    endcase
  end

  // Holding register in front of the queue.
  assign q_push      = hold_valid_r && !q_full;
  assign q_push_data = hold_cmd_r;
  assign in_ready    = engine_ready && (!hold_valid_r || !q_full);
  assign in_accept   = in_valid && in_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_cmd_nxt   = hold_cmd_r;
    if (in_accept) begin
      hold_valid_nxt = 1'b1;
      hold_cmd_nxt   = cmd_in;
    end else if (q_push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_cmd_r <= hold_cmd_nxt;
  end

endmodule

// ----- sv/tmw_cmd_queue.sv -----
// Short command queue between the front end and the engine of the text
// mode terminal writer. Depends on tmw_pkg for the command type and depth.
module tmw_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tmw_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output tmw_pkg::cmd_t pop_data,
  output logic          empty
);

  localparam int unsigned QAW    = tmw_pkg::QAW;
  localparam int unsigned QDEPTH = tmw_pkg::QDEPTH;

  tmw_pkg::cmd_t  entries_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW-1:0] rd_ptr_nxt;
  logic [QAW:0]   count_r;
  logic [QAW:0]   count_nxt;

  assign full     = (count_r == (QAW+1)'(QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entries_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? QAW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QAW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/tmw_engine.sv -----
// Engine of the text mode terminal writer: owns the screen memory and the
// cursor, carries out queued commands and holds the result register.
// Depends on tmw_pkg.
module tmw_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tmw_pkg::ATTR_W-1:0]    attr,
  input  logic                          q_empty,
  input  tmw_pkg::cmd_t                 q_data,
  output logic                          q_pop,
  output logic                          init_done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tmw_pkg::OUT_ROW_W-1:0] out_cursor_row,
  output logic [tmw_pkg::OUT_COL_W-1:0] out_cursor_col,
  output logic [tmw_pkg::OUT_POS_W-1:0] out_cursor_pos,
  output logic [tmw_pkg::CELL_W-1:0]    out_cell_data
);

  localparam int unsigned ROW_W     = tmw_pkg::ROW_W;
  localparam int unsigned COL_W     = tmw_pkg::COL_W;
  localparam int unsigned POS_W     = tmw_pkg::POS_W;
  localparam int unsigned CELL_W    = tmw_pkg::CELL_W;
  localparam int unsigned OUT_ROW_W = tmw_pkg::OUT_ROW_W;
  localparam int unsigned OUT_COL_W = tmw_pkg::OUT_COL_W;
  localparam int unsigned OUT_POS_W = tmw_pkg::OUT_POS_W;

  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(tmw_pkg::ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(tmw_pkg::COLUMNS - 1);
  localparam logic [POS_W-1:0] LAST_CELL = POS_W'(tmw_pkg::SCREEN_SIZE - 1);
  localparam logic [POS_W-1:0] LAST_ROW_START = POS_W'(tmw_pkg::LAST_ROW_START);

  // Sequencer states.
  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_TAB    = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_CLEAR  = 3'd4;
  localparam logic [2:0] ST_READ   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  k_r, k_nxt;
  logic [2:0]        tab_left_r, tab_left_nxt;
  logic [CELL_W-1:0] res_data_r, res_data_nxt;

  // Write stage in front of the memory port.
  logic              w_valid_r, w_valid_nxt;
  logic [POS_W-1:0]  w_addr_r, w_addr_nxt;
  logic              w_from_mem_r, w_from_mem_nxt;
  logic [CELL_W-1:0] w_data_r, w_data_nxt;

  logic [POS_W-1:0]  rd_addr;
  logic [CELL_W-1:0] rd_data_r;
  logic [CELL_W-1:0] screen_mem [tmw_pkg::SCREEN_SIZE];

  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_ROW_W-1:0] out_row_r, out_row_nxt;
  logic [OUT_COL_W-1:0] out_col_r, out_col_nxt;
  logic [OUT_POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [CELL_W-1:0]    out_data_r, out_data_nxt;

  // Cursor step helpers.
  logic              at_eol;
  logic              at_bottom;
  logic              put_scroll;
  logic              copy_phase;
  logic [CELL_W-1:0] blank_cell;
  logic [31:0]       row_ext;
  logic [31:0]       col_ext;
  logic [31:0]       pos_ext;

  assign at_eol     = (col_r == LAST_COL);
  assign at_bottom  = (row_r == LAST_ROW);
  assign put_scroll = at_eol && at_bottom;
  assign copy_phase = (32'(k_r) < tmw_pkg::COPY_CELLS);
  assign blank_cell = {attr, tmw_pkg::CH_SPACE};
  assign init_done  = (state_r != ST_INIT);

  assign row_ext = 32'(row_r);
  assign col_ext = 32'(col_r);
  assign pos_ext = 32'(pos_r);

  // Command sequencer.
  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    tab_left_nxt   = tab_left_r;
    res_data_nxt   = res_data_r;
    w_valid_nxt    = 1'b0;
    w_addr_nxt     = w_addr_r;
    w_from_mem_nxt = 1'b0;
    w_data_nxt     = w_data_r;
    rd_addr        = k_r;
    q_pop          = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_pos_nxt    = out_pos_r;
    out_data_nxt   = out_data_r;

    case (state_r)
      // Clearing pass after reset: every cell becomes a default blank.
      ST_INIT: begin
        w_valid_nxt = 1'b1;
        w_addr_nxt  = k_r;
        w_data_nxt  = {tmw_pkg::RESET_ATTR, tmw_pkg::CH_SPACE};
        if (k_r == LAST_CELL) begin
          k_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      ST_IDLE: begin
        rd_addr = q_data.idx;
        if (!q_empty) begin
          q_pop        = 1'b1;
          res_data_nxt = '0;
          case (q_data.op)
            tmw_pkg::OP_PUT: begin
              w_valid_nxt = 1'b1;
              w_addr_nxt  = pos_r;
              w_data_nxt  = {attr, q_data.ch};
              if (put_scroll) begin
                k_nxt        = '0;
                tab_left_nxt = '0;
                row_nxt      = LAST_ROW;
                col_nxt      = '0;
                pos_nxt      = LAST_ROW_START;
                state_nxt    = ST_SCROLL;
              end else begin
                col_nxt   = at_eol ? '0 : col_r + 1'b1;
                row_nxt   = at_eol ? row_r + 1'b1 : row_r;
                pos_nxt   = pos_r + 1'b1;
                state_nxt = ST_DONE;
              end
            end
            tmw_pkg::OP_NEWLINE: begin
              if (at_bottom) begin
                k_nxt        = '0;
                tab_left_nxt = '0;
                row_nxt      = LAST_ROW;
                col_nxt      = '0;
                pos_nxt      = LAST_ROW_START;
                state_nxt    = ST_SCROLL;
              end else begin
                row_nxt   = row_r + 1'b1;
                col_nxt   = '0;
                pos_nxt   = POS_W'(pos_ext - col_ext + tmw_pkg::COLUMNS);
                state_nxt = ST_DONE;
              end
            end
            tmw_pkg::OP_RETURN: begin
              col_nxt   = '0;
              pos_nxt   = POS_W'(pos_ext - col_ext);
              state_nxt = ST_DONE;
            end
            tmw_pkg::OP_TAB: begin
              tab_left_nxt = 3'(tmw_pkg::TAB_STOP - (col_ext % tmw_pkg::TAB_STOP));
              state_nxt    = ST_TAB;
            end
            tmw_pkg::OP_READ: begin
              state_nxt = ST_READ;
            end
            tmw_pkg::OP_CLEAR: begin
              k_nxt     = '0;
              row_nxt   = '0;
              col_nxt   = '0;
              pos_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // One space of a tab per cycle unless a scroll comes between; a space may wrap and scroll.
      ST_TAB: begin
        w_valid_nxt  = 1'b1;
        w_addr_nxt   = pos_r;
        w_data_nxt   = blank_cell;
        tab_left_nxt = tab_left_r - 1'b1;
        if (put_scroll) begin
          k_nxt     = '0;
          row_nxt   = LAST_ROW;
          col_nxt   = '0;
          pos_nxt   = LAST_ROW_START;
          state_nxt = ST_SCROLL;
        end else begin
          col_nxt   = at_eol ? '0 : col_r + 1'b1;
          row_nxt   = at_eol ? row_r + 1'b1 : row_r;
          pos_nxt   = pos_r + 1'b1;
          state_nxt = (tab_left_r == 3'd1) ? ST_DONE : ST_TAB;
        end
      end

      // Scroll: copy each cell up one row, then blank the bottom row.
      ST_SCROLL: begin
        rd_addr        = copy_phase ? POS_W'(32'(k_r) + tmw_pkg::COLUMNS) : k_r;
        w_valid_nxt    = 1'b1;
        w_addr_nxt     = k_r;
        w_from_mem_nxt = copy_phase;
        w_data_nxt     = blank_cell;
        if (k_r == LAST_CELL) begin
          k_nxt     = '0;
          state_nxt = (tab_left_r != '0) ? ST_TAB : ST_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      ST_CLEAR: begin
        w_valid_nxt = 1'b1;
        w_addr_nxt  = k_r;
        w_data_nxt  = blank_cell;
        if (k_r == LAST_CELL) begin
          k_nxt     = '0;
          state_nxt = ST_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      ST_READ: begin
        res_data_nxt = rd_data_r;
        state_nxt    = ST_DONE;
      end

      // Load the result register once it is free.
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = OUT_ROW_W'(row_ext);
          out_col_nxt   = OUT_COL_W'(col_ext);
          out_pos_nxt   = OUT_POS_W'(pos_ext);
          out_data_nxt  = res_data_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      row_r       <= '0;
      col_r       <= '0;
      pos_r       <= '0;
      k_r         <= '0;
      tab_left_r  <= '0;
      w_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      pos_r       <= pos_nxt;
      k_r         <= k_nxt;
      tab_left_r  <= tab_left_nxt;
      w_valid_r   <= w_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    res_data_r   <= res_data_nxt;
    w_addr_r     <= w_addr_nxt;
    w_from_mem_r <= w_from_mem_nxt;
    w_data_r     <= w_data_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_pos_r    <= out_pos_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Screen memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (w_valid_r) begin
      screen_mem[w_addr_r] <= w_from_mem_r ? rd_data_r : w_data_r;
    end
    rd_data_r <= screen_mem[rd_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_data  = out_data_r;

endmodule

// ----- sv/text_mode_terminal_writer.sv -----
// Channel   Direction  Handshake         Payload
// in_       input      in_valid/ready    kind, char_code, cell_index
// out_      output     out_valid/ready   cursor_row, cursor_col, cursor_pos, cell_data
// cfg_      input      cfg_we            cfg_index, cfg_wdata (colors)
//
// A printable character, return, newline or no-op passes the front end's holding
// register and the queue, then the engine states IDLE and DONE; a read also passes
// READ, and a tab passes TAB once per space. A scroll or a clear sweeps the whole
// screen memory at one cell per cycle through its single write port.
// After reset a clearing pass over every cell runs with in_ready low.
// The result register lets the engine take the next command while a result
// waits; the command queue lets the front end accept while the engine is busy.
//
// Top level of the text mode terminal writer. Depends on tmw_pkg, tmw_front,
// tmw_cmd_queue and tmw_engine.
module text_mode_terminal_writer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tmw_pkg::KIND_W-1:0]    in_kind,
  input  logic [tmw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tmw_pkg::IDX_W-1:0]     in_cell_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tmw_pkg::OUT_ROW_W-1:0] out_cursor_row,
  output logic [tmw_pkg::OUT_COL_W-1:0] out_cursor_col,
  output logic [tmw_pkg::OUT_POS_W-1:0] out_cursor_pos,
  output logic [tmw_pkg::CELL_W-1:0]    out_cell_data,
  input  logic                          cfg_we,
  input  logic [tmw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmw_pkg::COLOR_W-1:0]   cfg_wdata
);

  localparam int unsigned OUT_POS_W = tmw_pkg::OUT_POS_W;

  logic [tmw_pkg::COLOR_W-1:0] fg_r;
  logic [tmw_pkg::COLOR_W-1:0] bg_r;
  logic                        init_done;
  logic                        q_push;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_empty;
  tmw_pkg::cmd_t               q_push_data;
  tmw_pkg::cmd_t               q_pop_data;

  // Color registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= tmw_pkg::FG_RESET;
      bg_r <= tmw_pkg::BG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tmw_pkg::REG_FOREGROUND) begin
        fg_r <= cfg_wdata;
      end
      if (cfg_index == tmw_pkg::REG_BACKGROUND) begin
        bg_r <= cfg_wdata;
      end
    end
  end

  tmw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .engine_ready  (init_done),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_push_data   (q_push_data)
  );

  tmw_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  tmw_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .attr           ({bg_r, fg_r}),
    .q_empty        (q_empty),
    .q_data         (q_pop_data),
    .q_pop          (q_pop),
    .init_done      (init_done),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_data  (out_cell_data)
  );

  // The reported linear position always matches the reported row and column.
  a_pos_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_pos ==
      OUT_POS_W'(32'(out_cursor_row) * tmw_pkg::COLUMNS + 32'(out_cursor_col)))
    else $error("cursor position does not match row and column");

  // The reported cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_row) < tmw_pkg::ROWS) &&
                  (32'(out_cursor_col) < tmw_pkg::COLUMNS))
    else $error("cursor outside the screen");

  // No transaction is taken while the clearing pass after reset runs.
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> !in_ready)
    else $error("input accepted during the clearing pass");

endmodule
